// ===== design/ptrd_pkg.sv =====
package ptrd_pkg;

    // Fixed field widths of the stream words
    localparam int OP_W      = 2;
    localparam int TIME_W    = 32;
    localparam int TID_W     = 3;
    localparam int MASK_W    = 6;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    // Register file
    localparam int MAX_TASKS = 6;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_START_OFFSET = 3'd6;
    localparam logic [TIME_W-1:0]    PERIOD_RESET     = 32'd1000;

    // Alarm cap span, 2^31, carried at 33 bits
    localparam logic [TIME_W:0] CAP_SPAN = 33'h0_8000_0000;

    // Operation codes
    localparam logic [OP_W-1:0] OP_START    = 2'd0;
    localparam logic [OP_W-1:0] OP_ALARM    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd2;
    localparam logic [OP_W-1:0] OP_FINISH   = 2'd3;

    typedef logic [MAX_TASKS-1:0][TIME_W-1:0] period_arr_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan_step;
        logic load_out;
    } ptrd_cmd_t;

    typedef struct packed {
        logic is_alarm;
        logic scan_last;
    } ptrd_sts_t;

endpackage

// ===== design/ptrd_regs.sv =====
module ptrd_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptrd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output ptrd_pkg::period_arr_t         period,
    output logic [ptrd_pkg::TIME_W-1:0]   start_offset
);
    import ptrd_pkg::*;

    period_arr_t          period_reg;
    logic [TIME_W-1:0]    offset_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                period_reg[i] <= PERIOD_RESET;
            end
            offset_reg <= '0;
        end else if (wr_en) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                if (reg_idx == REG_IDX_W'(i)) begin
                    period_reg[i] <= pwdata;
                end
            end
            if (reg_idx == REG_START_OFFSET) begin
                offset_reg <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (reg_idx == REG_IDX_W'(i)) begin
                prdata = period_reg[i];
            end
        end
        if (reg_idx == REG_START_OFFSET) begin
            prdata = offset_reg;
        end
    end

    assign period       = period_reg;
    assign start_offset = offset_reg;

endmodule

// ===== design/ptrd_ctrl.sv =====
module ptrd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  ptrd_pkg::ptrd_sts_t sts,
    output ptrd_pkg::ptrd_cmd_t cmd
);
    import ptrd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.is_alarm ? ST_SCAN : ST_OUT;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result loaded over an untaken word");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

    a_valid_drops_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid_reg) |-> $past(m_tready))
        else $error("result word dropped without handshake");

    a_scan_after_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && sts.is_alarm) |=> (state_reg == ST_SCAN))
        else $error("alarm skipped its scan");

endmodule

// ===== design/ptrd_datapath.sv =====
module ptrd_datapath #(
    parameter int NUM_TASKS   = 6,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ptrd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [ptrd_pkg::OP_W-1:0]       s_tuser,
    input  ptrd_pkg::period_arr_t           period,
    input  logic [ptrd_pkg::TIME_W-1:0]     start_offset,
    input  ptrd_pkg::ptrd_cmd_t             cmd,
    output ptrd_pkg::ptrd_sts_t             sts,
    output logic [ptrd_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ptrd_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Latched input word
    logic [OP_W-1:0]   op_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TID_W-1:0]  tid_reg;

    // Task state
    logic [TIME_W-1:0]      rt_reg   [NUM_TASKS];
    logic [TIME_W-1:0]      rt_next  [NUM_TASKS];
    logic [COUNT_WIDTH-1:0] rc_reg   [NUM_TASKS];
    logic [COUNT_WIDTH-1:0] rc_next  [NUM_TASKS];
    logic [COUNT_WIDTH-1:0] pc_reg   [NUM_TASKS];
    logic [COUNT_WIDTH-1:0] pc_next  [NUM_TASKS];

    // Partial result of the execute step
    logic [MASK_W-1:0] rel_reg, rel_next;
    logic [MASK_W-1:0] miss_reg, miss_next;
    logic              gv_reg, gv_next;
    logic [TID_W-1:0]  gt_reg, gt_next;
    logic              err_reg, err_next;
    logic [TIME_W:0]   alarm_reg, alarm_init;

    logic [IDX_W-1:0]  idx_reg;

    // Output word
    logic [TIME_W-1:0] o_alarm_reg;
    logic [MASK_W-1:0] o_rel_reg, o_miss_reg;
    logic              o_gv_reg, o_err_reg;
    logic [TID_W-1:0]  o_gt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= s_tuser;
            now_reg <= s_tdata[TIME_W-1:0];
            tid_reg <= s_tdata[TIME_W+TID_W-1:TIME_W];
        end
    end

    always_comb begin
        logic found;
        found      = 1'b0;
        rel_next   = '0;
        miss_next  = '0;
        gv_next    = 1'b0;
        gt_next    = '0;
        err_next   = 1'b0;
        alarm_init = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            rt_next[i] = rt_reg[i];
            rc_next[i] = rc_reg[i];
            pc_next[i] = pc_reg[i];
        end
        case (op_reg)
            OP_START: begin
                alarm_init = {1'b0, start_offset};
                for (int i = 0; i < NUM_TASKS; i++) begin
                    rt_next[i] = period[i] + start_offset;
                    rc_next[i] = '0;
                    pc_next[i] = '0;
                end
            end
            OP_ALARM: begin
                alarm_init = {1'b0, now_reg} + CAP_SPAN;
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (rt_reg[i] <= now_reg) begin
                        rel_next[i]  = 1'b1;
                        miss_next[i] = (pc_reg[i] != '0);
                        if (rc_reg[i] == COUNT_MAX) begin
                            err_next = 1'b1;
                        end else begin
                            rc_next[i] = rc_reg[i] + 1'b1;
                        end
                        if (pc_reg[i] == COUNT_MAX) begin
                            err_next = 1'b1;
                        end else begin
                            pc_next[i] = pc_reg[i] + 1'b1;
                        end
                        rt_next[i] = rt_reg[i] + period[i];
                    end
                end
            end
            OP_DISPATCH: begin
                // grant the lowest-numbered task with a pending release
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (!found && rc_reg[i] != '0) begin
                        found      = 1'b1;
                        rc_next[i] = rc_reg[i] - 1'b1;
                        gv_next    = 1'b1;
                        gt_next    = TID_W'(i);
                    end
                end
            end
            OP_FINISH: begin
                for (int i = 0; i < NUM_TASKS; i++) begin
                    if (tid_reg == TID_W'(i)) begin
                        if (pc_reg[i] == '0) begin
                            err_next = 1'b1;
                        end else begin
                            pc_next[i] = pc_reg[i] - 1'b1;
                        end
                    end
                end
            end
            default: begin
                err_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                rt_reg[i] <= '0;
                rc_reg[i] <= '0;
                pc_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                rt_reg[i] <= rt_next[i];
                rc_reg[i] <= rc_next[i];
                pc_reg[i] <= pc_next[i];
            end
        end
    end

    // Execute latches the partial result; the scan folds one task per cycle
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rel_reg   <= rel_next;
            miss_reg  <= miss_next;
            gv_reg    <= gv_next;
            gt_reg    <= gt_next;
            err_reg   <= err_next;
            alarm_reg <= alarm_init;
        end else if (cmd.scan_step) begin
            if ({1'b0, rt_reg[idx_reg]} < alarm_reg) begin
                alarm_reg <= {1'b0, rt_reg[idx_reg]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.exec) begin
            idx_reg <= '0;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign sts.is_alarm  = (op_reg == OP_ALARM);
    assign sts.scan_last = (idx_reg == IDX_W'(NUM_TASKS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            o_alarm_reg <= alarm_reg[TIME_W-1:0];
            o_rel_reg   <= rel_reg;
            o_miss_reg  <= miss_reg;
            o_gv_reg    <= gv_reg;
            o_gt_reg    <= gt_reg;
            o_err_reg   <= err_reg;
        end
    end

    assign m_tdata = {{(M_TDATA_W - TIME_W - 2*MASK_W - TID_W - 2){1'b0}},
                      o_err_reg, o_gt_reg, o_gv_reg, o_miss_reg, o_rel_reg, o_alarm_reg};

endmodule

// ===== design/periodic_task_release_dispatcher.sv =====
// Sequence: an accepted word is executed, and for an alarm every task's release time is
//   then folded into the next-release minimum; the result word is loaded once the result register is free.
// Flow: a new word is accepted only after the last one's result word is loaded, and a
//   single shared compare scans the task release times one at a time for an alarm.
// Reset: aresetn synchronous, active low; clears counts, release times and result valid,
//   and sets every period to 1000 and the start offset to 0.
module periodic_task_release_dispatcher #(
    parameter int NUM_TASKS   = 6,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] now, [34:32] task_id, [39:35] zero
    input  logic [ptrd_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [ptrd_pkg::OP_W-1:0]       s_tuser,
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] wake_time, [37:32] released_mask, [43:38] miss_mask,
    // [44] grant_valid, [47:45] grant_task, [48] count_error, [55:49] zero
    output logic [ptrd_pkg::M_TDATA_W-1:0]  m_tdata,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptrd_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import ptrd_pkg::*;

    period_arr_t       period;
    logic [TIME_W-1:0] start_offset;
    ptrd_cmd_t         cmd;
    ptrd_sts_t         sts;

    // Period and start offset registers
    ptrd_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .period       (period),
        .start_offset (start_offset)
    );

    // Sequencer: accept, execute, scan (alarm only), then load the result word.
    // The result register frees the input side while a word waits downstream.
    ptrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Task state, release update, priority grant and wake-time fold
    ptrd_datapath #(
        .NUM_TASKS   (NUM_TASKS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .period       (period),
        .start_offset (start_offset),
        .cmd          (cmd),
        .sts          (sts),
        .m_tdata      (m_tdata)
    );

endmodule

// ===== dv/tb_periodic_task_release_dispatcher.sv =====
module tb_periodic_task_release_dispatcher;
    import ptrd_pkg::*;

    localparam int NUM_TASKS    = 6;
    localparam int COUNT_W      = 8;
    // Watchdog bound; leave a wide margin over the slowest correct run
    localparam int CYCLE_LIMIT  = 200000;
    // Pad past an alarm's scan of every task before touching registers
    localparam int DRAIN_CYCLES = NUM_TASKS + 6;
    // Receiver stops taking words for this long once, after HOLD_AFTER results
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 60;

    localparam logic [REG_IDX_W-1:0] REG_PERIOD_0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_4 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_5 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // One result word, unpacked into its fields
    typedef struct packed {
        logic [TIME_W-1:0] wake_time;
        logic [MASK_W-1:0] released;
        logic [MASK_W-1:0] missed;
        logic              grant_valid;
        logic [TID_W-1:0]  grant_task;
        logic              count_error;
    } answer_t;

    localparam answer_t NO_ANSWER = '0;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    // Directed row: an input word, or a register write done while idle
    typedef struct packed {
        row_kind_t         kind;
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] arg;    // now, or the register value
        logic [TID_W-1:0]  sel;    // task id, or the register index
        logic              fixed;  // answer below is typed in, not predicted
        answer_t           answer;
    } row_t;

    localparam int ROWS = 35;
    localparam row_t DIRECTED [ROWS] = '{
        // Alarm ahead of any start: every release time is zero, so all tasks go
        '{ROW_WORD, OP_ALARM,    32'd0, 3'd0, 1'b1,
          '{32'd1000, 6'h3F, 6'h00, 1'b0, 3'd0, 1'b0}},
        '{ROW_WORD, OP_ALARM,    32'd0, 3'd0, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_DISPATCH, 32'hFFFF_FFFF, 3'd7, 1'b1,
          '{32'd0, 6'h00, 6'h00, 1'b1, 3'd0, 1'b0}},
        '{ROW_WORD, OP_DISPATCH, 32'd0, 3'd0, 1'b1,
          '{32'd0, 6'h00, 6'h00, 1'b1, 3'd1, 1'b0}},
        '{ROW_WORD, OP_FINISH,   32'd0, 3'd0, 1'b0, NO_ANSWER},
        // Finish on a task with nothing unfinished
        '{ROW_WORD, OP_FINISH,   32'd0, 3'd0, 1'b1,
          '{32'd0, 6'h00, 6'h00, 1'b0, 3'd0, 1'b1}},
        // Task ids past the last task are dropped
        '{ROW_WORD, OP_FINISH,   32'hFFFF_FFFF, 3'd7, 1'b1, NO_ANSWER},
        '{ROW_WORD, OP_FINISH,   32'd0, 3'd6, 1'b1, NO_ANSWER},
        // Write past the register file is ignored
        '{ROW_REG,  OP_START,    32'd5,  REG_UNMAPPED,     1'b0, NO_ANSWER},
        '{ROW_REG,  OP_START,    32'h10, REG_START_OFFSET, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_START,    32'd0, 3'd0, 1'b1,
          '{32'h10, 6'h00, 6'h00, 1'b0, 3'd0, 1'b0}},
        // Dispatch with nothing pending
        '{ROW_WORD, OP_DISPATCH, 32'd0, 3'd0, 1'b1, NO_ANSWER},
        '{ROW_WORD, OP_ALARM,    32'd1015, 3'd0, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_ALARM,    32'd1016, 3'd0, 1'b0, NO_ANSWER},
        // Release while still unfinished: every task misses
        '{ROW_WORD, OP_ALARM,    32'hFFFF_FFFF, 3'd0, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_DISPATCH, 32'd0, 3'd0, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_FINISH,   32'd0, 3'd5, 1'b0, NO_ANSWER},
        // Widest periods and a large offset: release times wrap past 2^32
        '{ROW_REG,  OP_START,    32'hFFFF_FFFF, REG_PERIOD_0, 1'b0, NO_ANSWER},
        '{ROW_REG,  OP_START,    32'hFFFF_FFFF, REG_PERIOD_1, 1'b0, NO_ANSWER},
        '{ROW_REG,  OP_START,    32'hFFFF_FFFF, REG_PERIOD_2, 1'b0, NO_ANSWER},
        '{ROW_REG,  OP_START,    32'hFFFF_FFFF, REG_PERIOD_3, 1'b0, NO_ANSWER},
        '{ROW_REG,  OP_START,    32'hFFFF_FFFF, REG_PERIOD_4, 1'b0, NO_ANSWER},
        '{ROW_REG,  OP_START,    32'hFFFF_FFFF, REG_PERIOD_5, 1'b0, NO_ANSWER},
        '{ROW_REG,  OP_START,    32'h9000_0000, REG_START_OFFSET, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_START,    32'd0, 3'd0, 1'b1,
          '{32'h9000_0000, 6'h00, 6'h00, 1'b0, 3'd0, 1'b0}},
        // Nothing due and the earliest release lies past now + 2^31: capped; the second alarm releases all
        '{ROW_WORD, OP_ALARM,    32'd0, 3'd0, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_ALARM,    32'hFFFF_FFFF, 3'd0, 1'b0, NO_ANSWER},
        // Shortest period on task 0, zero offset
        '{ROW_REG,  OP_START,    32'd1, REG_PERIOD_0,     1'b0, NO_ANSWER},
        '{ROW_REG,  OP_START,    32'd0, REG_START_OFFSET, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_START,    32'd0, 3'd0, 1'b1, NO_ANSWER},
        '{ROW_WORD, OP_ALARM,    32'd0, 3'd0, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_ALARM,    32'd1, 3'd0, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_DISPATCH, 32'd0, 3'd0, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_FINISH,   32'd0, 3'd0, 1'b0, NO_ANSWER},
        '{ROW_WORD, OP_FINISH,   32'd0, 3'd0, 1'b0, NO_ANSWER}
    };

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [OP_W-1:0]        s_tuser  = OP_START;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Predictor copy of the task table and its registers
    logic [TIME_W-1:0]  period_cfg [NUM_TASKS];
    logic [TIME_W-1:0]  offset_cfg;
    logic [TIME_W-1:0]  rel_time   [NUM_TASKS];
    logic [COUNT_W-1:0] disp_cnt   [NUM_TASKS];  // releases waiting for a grant
    logic [COUNT_W-1:0] open_cnt   [NUM_TASKS];  // releases not yet finished

    answer_t answer_q [$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    int words_sent     = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int releases_seen  = 0;
    int misses_seen    = 0;
    int grants_seen    = 0;
    int errors_seen    = 0;

    periodic_task_release_dispatcher #(
        .NUM_TASKS   (NUM_TASKS),
        .COUNT_WIDTH (COUNT_W)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bring the predictor to its reset state
    function automatic void reset_tasks();
        int i;
        for (i = 0; i < NUM_TASKS; i++) begin
            period_cfg[i] = PERIOD_RESET;
            rel_time[i]   = '0;
            disp_cnt[i]   = '0;
            open_cnt[i]   = '0;
        end
        offset_cfg = '0;
    endfunction

    // Apply one input word to the task table and return the result word it causes
    function automatic answer_t advance_tasks(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
                                              logic [TID_W-1:0] tid);
        answer_t       r;
        logic [TIME_W:0] earliest;
        int            i;
        r = NO_ANSWER;
        case (op)
            OP_START: begin
                for (i = 0; i < NUM_TASKS; i++) begin
                    rel_time[i] = period_cfg[i] + offset_cfg;
                    disp_cnt[i] = '0;
                    open_cnt[i] = '0;
                end
                r.wake_time = offset_cfg;
            end
            OP_ALARM: begin
                // Cap is held at 33 bits so it never wraps
                earliest = {1'b0, now} + CAP_SPAN;
                for (i = 0; i < NUM_TASKS; i++) begin
                    if (rel_time[i] <= now) begin
                        if (open_cnt[i] != '0) r.missed[i] = 1'b1;
                        // Saturate both counts; the release itself still happens
                        if (disp_cnt[i] == '1) r.count_error = 1'b1;
                        else disp_cnt[i] = disp_cnt[i] + 1'b1;
                        if (open_cnt[i] == '1) r.count_error = 1'b1;
                        else open_cnt[i] = open_cnt[i] + 1'b1;
                        rel_time[i] = rel_time[i] + period_cfg[i];
                        r.released[i] = 1'b1;
                    end
                    if ({1'b0, rel_time[i]} < earliest) earliest = {1'b0, rel_time[i]};
                end
                r.wake_time = earliest[TIME_W-1:0];
            end
            OP_DISPATCH: begin
                // Lowest-numbered task with a waiting release wins
                for (i = 0; i < NUM_TASKS; i++) begin
                    if (!r.grant_valid && disp_cnt[i] != '0) begin
                        disp_cnt[i]   = disp_cnt[i] - 1'b1;
                        r.grant_valid = 1'b1;
                        r.grant_task  = i[TID_W-1:0];
                    end
                end
            end
            OP_FINISH: begin
                if (tid < NUM_TASKS) begin
                    if (open_cnt[tid] == '0) r.count_error = 1'b1;
                    else open_cnt[tid] = open_cnt[tid] - 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Compare one result word against the oldest expectation
    function automatic void compare_answer(logic [M_TDATA_W-1:0] word);
        answer_t got;
        answer_t want;
        got = '{word[31:0], word[37:32], word[43:38], word[44], word[47:45], word[48]};
        results_seen++;
        releases_seen += $countones(got.released);
        misses_seen   += $countones(got.missed);
        grants_seen   += got.grant_valid;
        errors_seen   += got.count_error;
        if (answer_q.size() == 0) begin
            $error("result word %h arrived with no expectation waiting", word);
            mismatch_count++;
            return;
        end
        want = answer_q.pop_front();
        if (got.wake_time !== want.wake_time) begin
            $error("wake_time: expected %h, got %h", want.wake_time, got.wake_time);
            mismatch_count++;
        end
        if (got.released !== want.released) begin
            $error("released_mask: expected %h, got %h", want.released, got.released);
            mismatch_count++;
        end
        if (got.missed !== want.missed) begin
            $error("miss_mask: expected %h, got %h", want.missed, got.missed);
            mismatch_count++;
        end
        if (got.grant_valid !== want.grant_valid) begin
            $error("grant_valid: expected %b, got %b", want.grant_valid, got.grant_valid);
            mismatch_count++;
        end
        if (got.grant_task !== want.grant_task) begin
            $error("grant_task: expected %0d, got %0d", want.grant_task, got.grant_task);
            mismatch_count++;
        end
        if (got.count_error !== want.count_error) begin
            $error("count_error: expected %b, got %b", want.count_error, got.count_error);
            mismatch_count++;
        end
    endfunction

    // Drop valid, wait for every expected word, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Two-phase register write; then idle with psel low so psel never toggles in a step
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_TASKS) period_cfg[idx] = value;
        else if (idx == REG_START_OFFSET) offset_cfg = value;
        @(posedge aclk);
    endtask

    // Offer one input word after a random gap, hold it until taken, then predict
    task automatic send_word(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                             input logic [TID_W-1:0] tid, input logic fixed,
                             input answer_t given);
        int      gap;
        answer_t predicted;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - TID_W - TIME_W){1'b0}}, tid, now};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        predicted = advance_tasks(op, now, tid);
        answer_q.push_back(fixed ? given : predicted);
    endtask

    // One phase: fresh registers, a start word, then mostly well-formed traffic
    task automatic run_phase(input int n_words, input bit flood, input int drain_at);
        int               k;
        int               i;
        int               base;
        int               step_max;
        int               pick;
        logic [OP_W-1:0]  op;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] sim_now;
        logic [TID_W-1:0] tid;
        settle();
        for (i = 0; i < NUM_TASKS; i++) begin
            // Flood: task 0 has no period, so it releases at every alarm and saturates
            if (flood) now = (i == 0) ? 32'd0 : 32'($urandom_range(1, 3));
            else begin
                case ($urandom_range(0, 9))
                    0: now = 32'd1;
                    1: now = '1;
                    2: now = '0;
                    default: now = $urandom_range(1, 60);
                endcase
            end
            write_reg(i[REG_IDX_W-1:0], now);
        end
        case ($urandom_range(0, 5))
            0: now = '0;
            1: now = '1;
            2: now = $urandom;
            default: now = $urandom_range(0, 100);
        endcase
        write_reg(REG_START_OFFSET, flood ? 32'd0 : now);

        step_max   = flood ? 2 : $urandom_range(1, 80);
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
        sim_now    = offset_cfg;
        send_word(OP_START, $urandom, TID_W'($urandom_range(0, 7)), 1'b0, NO_ANSWER);

        for (k = 1; k < n_words; k++) begin
            // Pause the sender until the result side has caught up
            if (k == drain_at || $urandom_range(0, 49) == 0) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (answer_q.size() != 0);
            end
            now  = $urandom;
            tid  = TID_W'($urandom_range(0, 7));
            pick = (flood && k < 275) ? 10 : $urandom_range(0, 99);
            if (pick < 3) begin
                op      = OP_START;
                sim_now = offset_cfg;
            end else if (pick < 45) begin
                // Mostly a running clock; now and then a stray time anywhere
                op = OP_ALARM;
                if ($urandom_range(0, 9) != 0) now = sim_now;
                sim_now = sim_now + $urandom_range(0, step_max);
            end else if (pick < 72) begin
                op = OP_DISPATCH;
            end else begin
                // Finish a task that has work open, unless this is noise
                op = OP_FINISH;
                if ($urandom_range(0, 6) != 0) begin
                    base = $urandom_range(0, NUM_TASKS - 1);
                    for (i = 0; i < NUM_TASKS; i++) begin
                        if (open_cnt[(base + i) % NUM_TASKS] != '0) begin
                            tid = TID_W'((base + i) % NUM_TASKS);
                            break;
                        end
                    end
                end
            end
            send_word(op, now, tid, 1'b0, NO_ANSWER);
        end
    endtask

    // Result side: random stalls, one long hold-off so the block backs up its input
    initial begin : result_sink
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (results_seen == HOLD_AFTER) gap = LONG_HOLD;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            compare_answer(m_tdata);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $error("run timed out with %0d results outstanding", answer_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int   k;
        int   p;
        row_t row;
        reset_tasks();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; registers only change with the block idle
        for (k = 0; k < ROWS; k++) begin
            row = DIRECTED[k];
            if (row.kind == ROW_REG) begin
                settle();
                write_reg(row.sel, row.arg);
            end else begin
                send_word(row.op, row.arg, row.sel, row.fixed, row.answer);
            end
        end

        // Saturation flood first, then random phases; the first one pauses mid-way
        run_phase(300, 1'b1, -1);
        for (p = 0; p < 4; p++) run_phase(50, 1'b0, (p == 0) ? 20 : -1);

        settle();
        $display("Covered %0d input words and %0d result words: %0d task releases,",
                 words_sent, results_seen, releases_seen);
        $display("%0d deadline misses, %0d grants, %0d count errors; %0d mismatches.",
                 misses_seen, grants_seen, errors_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ptrd_pkg.sv
design/ptrd_regs.sv
design/ptrd_ctrl.sv
design/ptrd_datapath.sv
design/periodic_task_release_dispatcher.sv
dv/tb_periodic_task_release_dispatcher.sv
